>>> rtl/matrix4_vector_transform_top_macros.svh
// Assertion helpers for the matrix transform block.
`ifndef MATRIX4_VECTOR_TRANSFORM_TOP_MACROS_SVH
`define MATRIX4_VECTOR_TRANSFORM_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define M4VT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("m4vt assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define M4VT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("m4vt assertion failed");

`endif

>>> rtl/m4vt_pkg.sv
package m4vt_pkg;

  localparam int FIELD_W          = 32;
  localparam int LANES            = 4;
  localparam int ELEMENT_BITS_DEF = 32;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_XFORM = 1'b1;

  // Per-stage advance strobes shared by all lanes.
  typedef struct packed {
    logic adv1;
    logic adv2;
  } m4vt_ctrl_t;

endpackage

>>> rtl/m4vt_lane.sv
module m4vt_lane
  import m4vt_pkg::*;
#(
  parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
  input  logic                           clk,
  input  m4vt_ctrl_t                     ctrl,
  input  logic        [ELEMENT_BITS-1:0] word [LANES],
  input  logic        [ELEMENT_BITS-1:0] vec  [LANES],
  output logic        [ELEMENT_BITS-1:0] sat_val,
  output logic                           clip
);

  localparam int PW = 2 * ELEMENT_BITS;
  localparam int SW = PW + 2;

  logic signed [PW-1:0]   prod_r [LANES];
  logic signed [PW:0]     pair_r [2];
  logic signed [SW-1:0]   sum;
  logic [SW-ELEMENT_BITS:0] top_bits;

  always_ff @(posedge clk) begin
    if (ctrl.adv1) begin
      for (int j = 0; j < LANES; j++) begin
        prod_r[j] <= $signed(word[j]) * $signed(vec[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv2) begin
      pair_r[0] <= (PW+1)'(prod_r[0]) + (PW+1)'(prod_r[1]);
      pair_r[1] <= (PW+1)'(prod_r[2]) + (PW+1)'(prod_r[3]);
    end
  end

  // Result fits when every bit from the element sign bit up agrees.
  always_comb begin
    sum      = SW'(pair_r[0]) + SW'(pair_r[1]);
    top_bits = sum[SW-1:ELEMENT_BITS-1];
    clip     = !((&top_bits) || !(|top_bits));
    if (!clip) begin
      sat_val = sum[ELEMENT_BITS-1:0];
    end else if (sum[SW-1]) begin
      sat_val = {1'b1, {(ELEMENT_BITS-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(ELEMENT_BITS-1){1'b1}}};
    end
  end

endmodule

>>> rtl/m4vt_merge.sv
module m4vt_merge
  import m4vt_pkg::*;
#(
  parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv3,
  input  logic                         in_valid,
  input  logic [ELEMENT_BITS-1:0]      sat_val [LANES],
  input  logic [LANES-1:0]             clip,
  output logic                         out_tvalid,
  output logic [LANES*FIELD_W-1:0]     out_tdata,
  output logic [0:0]                   out_tuser
);

  logic                     valid_r, valid_nxt;
  logic [LANES*FIELD_W-1:0] data_r, data_nxt;
  logic                     sat_r, sat_nxt;

  always_comb begin
    valid_nxt = adv3 ? in_valid : valid_r;
    data_nxt  = data_r;
    sat_nxt   = sat_r;
    if (adv3) begin
      for (int i = 0; i < LANES; i++) begin
        data_nxt[i*FIELD_W +: FIELD_W] = FIELD_W'($signed(sat_val[i]));
      end
      sat_nxt = |clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    sat_r  <= sat_nxt;
  end

  assign out_tvalid   = valid_r;
  assign out_tdata    = data_r;
  assign out_tuser[0] = sat_r;

endmodule

>>> rtl/matrix4_vector_transform_top.sv
// Pipeline: a transform transaction moves from its acceptance edge through multiply,
// pair-add and final add/saturate into the output register; out_tready stalls hold it.
// Throughput: one transaction per cycle while out_tready does not stall, loads and
// transforms alike; a load updates the matrix at its acceptance edge and gives no result.
// Reset (synchronous, rst_n low): matrix cleared to zero, row-major layout,
// pipeline and output register empty.
`include "matrix4_vector_transform_top_macros.svh"

module matrix4_vector_transform_top
  import m4vt_pkg::*;
#(
  parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_wdata,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [LANES*FIELD_W-1:0] in_tdata,   // elem_0, elem_1, elem_2, elem_3
  input  logic [2:0]               in_tuser,   // kind, group_index[1:0]
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [LANES*FIELD_W-1:0] out_tdata,  // res_0, res_1, res_2, res_3
  output logic [0:0]               out_tuser   // saturated
);

  localparam int WORDS = LANES * LANES;

  logic                    col_major_r;
  logic [ELEMENT_BITS-1:0] mat_r   [WORDS];
  logic [ELEMENT_BITS-1:0] mat_nxt [WORDS];
  logic [ELEMENT_BITS-1:0] vec     [LANES];
  logic                    v1_r, v1_nxt, v2_r, v2_nxt;
  logic                    adv3;
  logic                    in_fire;
  logic                    kind;
  logic [1:0]              grp;
  m4vt_ctrl_t              ctrl;
  logic [ELEMENT_BITS-1:0] sat_val [LANES];
  logic [LANES-1:0]        clip;

  assign kind    = in_tuser[0];
  assign grp     = in_tuser[2:1];
  assign in_fire = in_tvalid && in_tready;

  // Each stage moves when the one after it is empty or moving.
  assign adv3      = !out_tvalid || out_tready;
  assign ctrl.adv2 = !v2_r || adv3;
  assign ctrl.adv1 = !v1_r || ctrl.adv2;
  assign in_tready = ctrl.adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_major_r <= 1'b0;
    end else if (cfg_we) begin
      col_major_r <= cfg_wdata[0];
    end
  end

  always_comb begin
    for (int k = 0; k < WORDS; k++) begin
      mat_nxt[k] = mat_r[k];
      if (in_fire && kind == KIND_LOAD && grp == 2'(k / LANES)) begin
        mat_nxt[k] = in_tdata[(k % LANES)*FIELD_W +: ELEMENT_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WORDS; k++) begin
        mat_r[k] <= '0;
      end
    end else begin
      mat_r <= mat_nxt;
    end
  end

  always_comb begin
    v1_nxt = ctrl.adv1 ? (in_fire && kind == KIND_XFORM) : v1_r;
    v2_nxt = ctrl.adv2 ? v1_r : v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  genvar gi, gj;
  generate
    for (gj = 0; gj < LANES; gj++) begin : g_vec
      assign vec[gj] = in_tdata[gj*FIELD_W +: ELEMENT_BITS];
    end
    for (gi = 0; gi < LANES; gi++) begin : g_lane
      logic [ELEMENT_BITS-1:0] word [LANES];
      for (gj = 0; gj < LANES; gj++) begin : g_word
        assign word[gj] = col_major_r ? mat_r[gj*LANES + gi] : mat_r[gi*LANES + gj];
      end
      m4vt_lane #(
        .ELEMENT_BITS(ELEMENT_BITS)
      ) u_lane (
        .clk     (clk),
        .ctrl    (ctrl),
        .word    (word),
        .vec     (vec),
        .sat_val (sat_val[gi]),
        .clip    (clip[gi])
      );
    end
  endgenerate

  m4vt_merge #(
    .ELEMENT_BITS(ELEMENT_BITS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv3       (adv3),
    .in_valid   (v2_r),
    .sat_val    (sat_val),
    .clip       (clip),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `M4VT_ASSERT_NEXT(a_xform_enters, in_fire && kind == KIND_XFORM, v1_r)
  `M4VT_ASSERT_NEXT(a_stage1_holds, v1_r && !ctrl.adv2, v1_r)
  `M4VT_ASSERT_NOW(a_stall_only_full, !in_tready, v1_r && v2_r && out_tvalid)

endmodule
